[rtl/core/rc4_pkg.sv]
// Shared types and constants for the RC4 cipher engine.
package rc4_pkg;

  localparam int BYTE_W     = 8;
  localparam int PERM_DEPTH = 256;
  localparam int PERM_AW    = 8;

  localparam logic ACTION_KEY  = 1'b0;
  localparam logic ACTION_DATA = 1'b1;

  typedef logic [BYTE_W-1:0] byte_t;

  // A write to the permutation memory that waits for a free write slot.
  typedef struct packed {
    logic                 en;
    logic [PERM_AW-1:0]   addr;
    byte_t                data;
  } perm_wr_t;

endpackage

[rtl/core/rc4_stream_if.sv]
// Handshake channel interfaces for the RC4 cipher engine input and result streams.
interface rc4_in_if;
  logic          valid;
  logic          ready;
  logic          action;
  rc4_pkg::byte_t byte_in;
  logic          last_key;

  modport source (output valid, output action, output byte_in, output last_key, input ready);
  modport sink   (input valid, input action, input byte_in, input last_key, output ready);
endinterface

interface rc4_out_if;
  logic           valid;
  logic           ready;
  rc4_pkg::byte_t byte_out;

  modport source (output valid, output byte_out, input ready);
  modport sink   (input valid, input byte_out, output ready);
endinterface

[rtl/core/rc4_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module rc4_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/rc4_stream_cipher_unit.sv]
// Top level of the RC4 cipher engine: key store, key schedule and byte cipher.
//
//   Channel  Dir  Payload                      Transfer
//   in_ch    in   action, byte_in, last_key    valid && ready
//   out_ch   out  byte_out                     valid && ready
//
// A data byte occupies the permutation memory through states ST_IDLE, ST_D1
// and ST_D2: its three reads (S[i], S[j], keystream entry) depend on each
// other through the one read port, whose read data is registered. The final
// key byte is followed by the key schedule, states ST_K0, ST_K1 and ST_K2
// for each permutation entry, during which no transfer is taken on in_ch.
// Reset is synchronous and active low. The identity permutation is supplied
// by a valid bit per entry, so neither reset nor a new key needs a clearing
// pass. A stalled out_ch holds at most one result; the next data byte's
// result waits in the pipeline and, in ST_IDLE, in_ch is held off only
// while it waits.
module rc4_stream_cipher_unit #(
  parameter int KEY_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  rc4_in_if.sink        in_ch,
  rc4_out_if.source     out_ch
);

  localparam int KAW = (KEY_DEPTH > 1) ? $clog2(KEY_DEPTH) : 1;
  localparam int KCW = $clog2(KEY_DEPTH + 1);
  localparam int AW  = rc4_pkg::PERM_AW;

  // Sequencer states: idle, data read of S[j], data swap, and three key
  // schedule steps per entry.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_D1   = 3'd1;
  localparam logic [2:0] ST_D2   = 3'd2;
  localparam logic [2:0] ST_K0   = 3'd3;
  localparam logic [2:0] ST_K1   = 3'd4;
  localparam logic [2:0] ST_K2   = 3'd5;

  logic [2:0] state_r, state_nxt;

  // Cipher indices and working registers.
  logic [AW-1:0]    i_r, j_r;
  rc4_pkg::byte_t   sx_r;
  rc4_pkg::byte_t   data_r;
  logic             res_pend_r;

  // Key schedule registers.
  logic [AW-1:0]    n_r;
  logic [AW-1:0]    acc_r;
  rc4_pkg::byte_t   sn_r;
  logic [KAW-1:0]   kidx_r;
  logic [KCW-1:0]   key_len_r;
  logic [KCW-1:0]   key_count_r;

  rc4_pkg::perm_wr_t pend_r;

  // One valid bit per permutation entry; an invalid entry reads as its own
  // address, which is the identity permutation.
  logic [rc4_pkg::PERM_DEPTH-1:0] pvld_r;

  // Read-side bookkeeping for the permutation memory.
  logic [AW-1:0]    rd_addr_r;
  logic             rd_fwd_r;
  rc4_pkg::byte_t   rd_fwd_data_r;
  logic             rd_vld_r;

  logic             out_valid_r;
  rc4_pkg::byte_t   out_byte_r;

  // Permutation memory ports.
  logic             p_we, p_re;
  logic [AW-1:0]    p_waddr, p_raddr;
  rc4_pkg::byte_t   p_wdata, p_rdata;

  // Key memory ports.
  logic             k_we, k_re;
  logic [KAW-1:0]   k_waddr;
  rc4_pkg::byte_t   k_rdata;

  logic             in_fire;
  logic             key_start;
  logic             out_free;
  logic             out_load;
  logic             pend_take;
  logic             key_store_ok;
  logic [KCW-1:0]   key_count_inc;
  logic [KCW-1:0]   kidx_inc;
  rc4_pkg::byte_t   rd_val;
  rc4_pkg::byte_t   ks_byte;
  logic [AW-1:0]    acc_sum;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign key_start = in_fire && (in_ch.action == rc4_pkg::ACTION_KEY) && in_ch.last_key;
  assign out_free  = !out_valid_r || out_ch.ready;
  assign out_load  = (state_r == ST_IDLE) && res_pend_r && out_free;

  assign in_ch.ready    = (state_r == ST_IDLE) && (!res_pend_r || out_free);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.byte_out = out_byte_r;

  // Read data as it stands after any write in the cycle of the read.
  assign rd_val = rd_fwd_r ? rd_fwd_data_r : (rd_vld_r ? p_rdata : rd_addr_r);

  // After the swap, S[j] holds sx; the forwarded write covers S[i].
  assign ks_byte = (rd_addr_r == j_r) ? sx_r : rd_val;

  assign acc_sum = acc_r + k_rdata + rd_val;

  assign key_store_ok  = (key_count_r < KCW'(KEY_DEPTH));
  assign key_count_inc = key_count_r + KCW'(key_store_ok);
  assign kidx_inc      = KCW'(kidx_r) + KCW'(1);

  // A waiting write goes out in ST_IDLE or ST_K0, which make no write of their own.
  assign pend_take = pend_r.en && ((state_r == ST_IDLE) || (state_r == ST_K0));

  assign k_we    = in_fire && (in_ch.action == rc4_pkg::ACTION_KEY) && key_store_ok;
  assign k_waddr = key_count_r[KAW-1:0];
  assign k_re    = (state_r == ST_K0);

  always_comb begin
    state_nxt = state_r;
    p_we      = 1'b0;
    p_waddr   = pend_r.addr;
    p_wdata   = pend_r.data;
    p_re      = 1'b0;
    p_raddr   = i_r + AW'(1);
    if (pend_take) begin
      p_we = 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.action == rc4_pkg::ACTION_DATA) begin
            p_re      = 1'b1;
            state_nxt = ST_D1;
          end else if (in_ch.last_key) begin
            state_nxt = ST_K0;
          end
        end
      end
      ST_D1: begin
        p_re      = 1'b1;
        p_raddr   = j_r + rd_val;
        state_nxt = ST_D2;
      end
      ST_D2: begin
        p_we      = 1'b1;
        p_waddr   = i_r;
        p_wdata   = rd_val;
        p_re      = 1'b1;
        p_raddr   = sx_r + rd_val;
        state_nxt = ST_IDLE;
      end
      ST_K0: begin
        p_re      = 1'b1;
        p_raddr   = n_r;
        state_nxt = ST_K1;
      end
      ST_K1: begin
        p_re      = 1'b1;
        p_raddr   = acc_sum;
        state_nxt = ST_K2;
      end
      ST_K2: begin
        p_we      = 1'b1;
        p_waddr   = n_r;
        p_wdata   = rd_val;
        state_nxt = (n_r == '1) ? ST_IDLE : ST_K0;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pend_r.en   <= 1'b0;
      res_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pvld_r      <= '0;
      key_count_r <= '0;
      i_r         <= '0;
      j_r         <= '0;
    end else begin
      state_r <= state_nxt;

      if (p_re) begin
        rd_addr_r     <= p_raddr;
        rd_fwd_r      <= p_we && (p_waddr == p_raddr);
        rd_fwd_data_r <= p_wdata;
        rd_vld_r      <= pvld_r[p_raddr];
      end
      // A new key restarts from the identity permutation, which also
      // discards a swap write still waiting from the last data byte.
      if (key_start) begin
        pvld_r <= '0;
      end else if (p_we) begin
        pvld_r[p_waddr] <= 1'b1;
      end
      if (pend_take) begin
        pend_r.en <= 1'b0;
      end

      if (out_load) begin
        out_byte_r <= data_r ^ ks_byte;
        res_pend_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.action == rc4_pkg::ACTION_DATA) begin
              i_r    <= i_r + AW'(1);
              data_r <= in_ch.byte_in;
            end else if (in_ch.last_key) begin
              key_len_r   <= key_count_inc;
              key_count_r <= '0;
              i_r         <= '0;
              j_r         <= '0;
              n_r         <= '0;
              acc_r       <= '0;
              kidx_r      <= '0;
            end else begin
              key_count_r <= key_count_inc;
            end
          end
        end
        ST_D1: begin
          sx_r <= rd_val;
          j_r  <= j_r + rd_val;
        end
        ST_D2: begin
          pend_r     <= '{en: 1'b1, addr: j_r, data: sx_r};
          res_pend_r <= 1'b1;
        end
        ST_K0: begin
          kidx_r <= (kidx_inc == key_len_r) ? '0 : kidx_inc[KAW-1:0];
        end
        ST_K1: begin
          sn_r  <= rd_val;
          acc_r <= acc_sum;
        end
        ST_K2: begin
          pend_r <= '{en: 1'b1, addr: acc_r, data: sn_r};
          n_r    <= n_r + AW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (rc4_pkg::PERM_DEPTH)
  ) u_perm_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (p_wdata),
    .re    (p_re),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  rc4_ram #(
    .WIDTH (rc4_pkg::BYTE_W),
    .DEPTH (KEY_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (in_ch.byte_in),
    .re    (k_re),
    .raddr (kidx_r),
    .rdata (k_rdata)
  );

endmodule
